@@ rtl/ps2d_pkg.sv @@
// Package for the PS/2 set-2 scan-code decoder: result kinds, prefix and key codes,
// the release-to-character table and the chord dot lookup.
// No dependencies.
package ps2d_pkg;

    localparam int CODE_W  = 8;
    localparam int VALUE_W = 8;
    localparam int DOTS_W  = 6;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_FUNC = 2'd1,
        KIND_DOTS = 2'd2
    } t_kind;

    typedef enum logic {
        MODE_FULL  = 1'b0,
        MODE_CHORD = 1'b1
    } t_mode;

    localparam logic [CODE_W-1:0] PFX_EXT   = 8'hE0;
    localparam logic [CODE_W-1:0] PFX_BRK   = 8'hF0;
    localparam logic [CODE_W-1:0] KEY_SPACE = 8'h29;
    localparam logic [CODE_W-1:0] KEY_NONE  = 8'h00;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] char_code;
    } t_map;

    function automatic t_map f_key_map(input logic [CODE_W-1:0] code);
        t_map m;
        m.hit = 1'b1;
        case (code)
            8'h45: m.char_code = "0";
            8'h16: m.char_code = "1";
            8'h1E: m.char_code = "2";
            8'h26: m.char_code = "3";
            8'h25: m.char_code = "4";
            8'h2E: m.char_code = "5";
            8'h36: m.char_code = "6";
            8'h3D: m.char_code = "7";
            8'h3E: m.char_code = "8";
            8'h46: m.char_code = "9";
            8'h1C: m.char_code = "a";
            8'h32: m.char_code = "b";
            8'h21: m.char_code = "c";
            8'h23: m.char_code = "d";
            8'h24: m.char_code = "e";
            8'h2B: m.char_code = "f";
            8'h34: m.char_code = "g";
            8'h33: m.char_code = "h";
            8'h43: m.char_code = "i";
            8'h3B: m.char_code = "j";
            8'h42: m.char_code = "k";
            8'h4B: m.char_code = "l";
            8'h3A: m.char_code = "m";
            8'h31: m.char_code = "n";
            8'h4C: m.char_code = 8'hEE;
            8'h44: m.char_code = "o";
            8'h4D: m.char_code = "p";
            8'h15: m.char_code = "q";
            8'h2D: m.char_code = "r";
            8'h1B: m.char_code = "s";
            8'h2C: m.char_code = "t";
            8'h3C: m.char_code = "u";
            8'h2A: m.char_code = "v";
            8'h1D: m.char_code = "w";
            8'h22: m.char_code = "x";
            8'h35: m.char_code = "y";
            8'h1A: m.char_code = "z";
            8'h58: m.char_code = "^";
            8'h0D: m.char_code = "#";
            8'h5A: m.char_code = 8'h0A;
            8'h41: m.char_code = ",";
            8'h49: m.char_code = ".";
            8'h4A: m.char_code = "_";
            8'h4E: m.char_code = "?";
            8'h5D: m.char_code = ";";
            8'h55: m.char_code = "!";
            8'h54: m.char_code = "(";
            8'h52: m.char_code = ")";
            8'h0E: m.char_code = 8'h22;
            8'h5B: m.char_code = "*";
            8'h29: m.char_code = " ";
            default: begin
                m.hit       = 1'b0;
                m.char_code = '0;
            end
        endcase
        return m;
    endfunction

    function automatic logic [DOTS_W-1:0] f_dot_of(input logic [CODE_W-1:0] code);
        logic [DOTS_W-1:0] d;
        case (code)
            8'h2B:   d = 6'b000001;
            8'h23:   d = 6'b000010;
            8'h1B:   d = 6'b000100;
            8'h3B:   d = 6'b001000;
            8'h42:   d = 6'b010000;
            8'h4B:   d = 6'b100000;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/ps2d_scan_if.sv @@
// Scan-code input channel: valid/ready handshake with the received byte and clear flag.
// Depends on ps2d_pkg.
interface ps2d_scan_if;
    logic                         valid;
    logic                         ready;
    logic [ps2d_pkg::CODE_W-1:0]  scan_code;
    logic                         clear_decoder;

    modport source (output valid, output scan_code, output clear_decoder, input ready);
    modport sink   (input valid, input scan_code, input clear_decoder, output ready);
endinterface

@@ rtl/ps2d_key_if.sv @@
// Decoded key result channel: valid/ready handshake with result kind and value.
// Depends on ps2d_pkg.
interface ps2d_key_if;
    logic                         valid;
    logic                         ready;
    ps2d_pkg::t_kind              result_kind;
    logic [ps2d_pkg::VALUE_W-1:0] result_value;

    modport source (output valid, output result_kind, output result_value, input ready);
    modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

@@ rtl/ps2_scan_code_decoder_top.sv @@
// PS/2 set-2 scan-code decoder: prefix tracking, table lookup and braille chord entry.
// Depends on ps2d_pkg, ps2d_scan_if and ps2d_key_if.
// Path: the input register captures a scan beat, then the result register takes its result beat.
// Throughput: one scan beat per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset (synchronous, active low) clears mode, prefix flags, dots and both valid flags.
module ps2_scan_code_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    ps2d_scan_if.sink         i_scan,
    ps2d_key_if.source        o_key
);

    logic                          r_in_vld;
    logic [ps2d_pkg::CODE_W-1:0]   r_code;
    logic                          r_clear;

    ps2d_pkg::t_mode               r_mode;
    logic                          r_brk;
    logic                          r_ext;
    logic [ps2d_pkg::DOTS_W-1:0]   r_dots;

    logic                          r_out_vld;
    ps2d_pkg::t_kind               r_kind;
    logic [ps2d_pkg::VALUE_W-1:0]  r_value;

    logic                          n_brk;
    logic                          n_ext;
    logic [ps2d_pkg::DOTS_W-1:0]   n_dots;
    logic                          n_emit;
    ps2d_pkg::t_kind               n_kind;
    logic [ps2d_pkg::VALUE_W-1:0]  n_value;

    logic                          advance;
    logic [ps2d_pkg::DOTS_W-1:0]   dot;
    ps2d_pkg::t_map                map;

    assign advance      = r_in_vld && (!r_out_vld || o_key.ready);
    assign i_scan.ready = !r_in_vld || advance;

    assign o_key.valid        = r_out_vld;
    assign o_key.result_kind  = r_kind;
    assign o_key.result_value = r_value;

    assign dot = ps2d_pkg::f_dot_of(r_code);
    assign map = ps2d_pkg::f_key_map(r_code);

    always_comb begin
        n_brk   = r_brk;
        n_ext   = r_ext;
        n_dots  = r_dots;
        n_emit  = 1'b0;
        n_kind  = ps2d_pkg::KIND_FUNC;
        n_value = r_code;
        if (r_clear) begin
            n_brk = 1'b0;
            n_ext = 1'b0;
        end else if (r_code == ps2d_pkg::PFX_EXT) begin
            n_ext = 1'b1;
        end else if (r_code == ps2d_pkg::PFX_BRK) begin
            n_brk = 1'b1;
        end else begin
            n_brk = 1'b0;
            n_ext = 1'b0;
            if (r_brk) begin
                if (r_ext) begin
                    n_emit = (r_code != ps2d_pkg::KEY_NONE);
                end else if (r_mode == ps2d_pkg::MODE_CHORD) begin
                    if (dot != '0) begin
                        n_dots = r_dots & ~dot;
                    end else if (r_code == ps2d_pkg::KEY_SPACE) begin
                        n_emit  = 1'b1;
                        n_kind  = ps2d_pkg::KIND_DOTS;
                        n_value = {2'b00, r_dots};
                    end else begin
                        n_emit = (r_code != ps2d_pkg::KEY_NONE);
                    end
                end else if (map.hit) begin
                    n_emit  = 1'b1;
                    n_kind  = ps2d_pkg::KIND_CHAR;
                    n_value = map.char_code;
                end else begin
                    n_emit = (r_code != ps2d_pkg::KEY_NONE);
                end
            end else if (r_mode == ps2d_pkg::MODE_CHORD) begin
                n_dots = r_dots | dot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= ps2d_pkg::MODE_FULL;
            r_brk     <= 1'b0;
            r_ext     <= 1'b0;
            r_dots    <= '0;
        end else begin
            if (i_scan.valid && i_scan.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= n_emit;
                r_brk     <= n_brk;
                r_ext     <= n_ext;
            end else if (o_key.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_mode <= ps2d_pkg::t_mode'(i_cfg_wr_data);
                r_dots <= '0;
            end else if (advance) begin
                r_dots <= n_dots;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_code  <= i_scan.scan_code;
            r_clear <= i_scan.clear_decoder;
        end
        if (advance && n_emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

    a_dots_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && o_key.result_kind == ps2d_pkg::KIND_DOTS)
            |-> (o_key.result_value[7:6] == 2'b00))
        else $error("dot pattern beat carries upper bits");

    a_func_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && o_key.result_kind == ps2d_pkg::KIND_FUNC)
            |-> (o_key.result_value != ps2d_pkg::KEY_NONE))
        else $error("function beat carries the no-key code");

    a_cfg_clears_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_dots == '0))
        else $error("dots not cleared by mode write");

    a_full_mode_no_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ps2d_pkg::MODE_FULL) |-> (r_dots == '0))
        else $error("dots set in full keyboard mode");

    a_result_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(advance))
        else $error("result beat without an advancing scan beat");

endmodule
